// ----- design/stfp_pkg.sv -----
package stfp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hff;

    // Parser phases
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SKIP = 2'd1;
    localparam logic [1:0] PH_TYPE = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    // Frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;

    // Shortest frame that the table can give
    localparam logic [4:0] MIN_LENGTH = 5'd6;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [1:0]  frame_status;
        logic [7:0]  prefix_byte;
        logic [4:0]  frame_length;
        logic [11:0] sum_computed;
        logic [15:0] sum_received;
    } result_t;

    function automatic logic [4:0] length_of_type(input logic [7:0] t);
        logic [4:0] len;
        case (t)
            8'h41:   len = 5'd17;
            8'h42:   len = 5'd12;
            8'h44:   len = 5'd7;
            8'h46:   len = 5'd8;
            8'h47:   len = 5'd6;
            8'h48:   len = 5'd11;
            8'h60:   len = 5'd12;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- design/stfp_parser.sv -----
module stfp_parser
    import stfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  prefix_reg, prefix_next;
    logic [7:0]  type_reg, type_next;
    logic [4:0]  len_reg, len_next;
    logic [4:0]  pos_reg, pos_next;
    logic [11:0] sum_reg, sum_next;
    logic [7:0]  cks_lo_reg, cks_lo_next;

    logic [4:0]  table_len;
    logic [4:0]  last_body;
    logic [15:0] rcv;

    assign table_len = length_of_type(rx_byte);
    assign last_body = len_reg - 5'd2;
    assign rcv       = {rx_byte, cks_lo_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cks_lo_next = cks_lo_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.frame_type  = type_reg;
        res.prefix_byte = prefix_reg;

        if (step)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_BYTE)
                        phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (rx_byte != SYNC_BYTE)
                    begin
                        prefix_next = rx_byte;
                        phase_next  = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next = rx_byte;
                    if (table_len == 5'd0)
                    begin
                        len_next         = 5'd0;
                        phase_next       = PH_HUNT;
                        res_valid        = 1'b1;
                        res.frame_type   = rx_byte;
                        res.frame_status = ST_UNKNOWN;
                    end
                    else
                    begin
                        len_next    = table_len;
                        pos_next    = 5'd2;
                        sum_next    = {3'd0, {1'b0, prefix_reg} + {1'b0, rx_byte}};
                        cks_lo_next = 8'd0;
                        phase_next  = PH_BODY;
                    end
                end
                default:
                begin
                    if (len_reg < MIN_LENGTH)
                        phase_next = PH_HUNT;
                    else if (pos_reg < last_body)
                    begin
                        sum_next = sum_reg + {4'd0, rx_byte};
                        pos_next = pos_reg + 5'd1;
                    end
                    else if (pos_reg == last_body)
                    begin
                        cks_lo_next = rx_byte;
                        pos_next    = pos_reg + 5'd1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.frame_status = ({4'd0, sum_reg} == rcv) ? ST_OK : ST_MISMATCH;
                        res.frame_length = len_reg;
                        res.sum_computed = sum_reg;
                        res.sum_received = rcv;
                        phase_next       = PH_HUNT;
                        pos_next         = 5'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            prefix_reg <= 8'd0;
            type_reg   <= 8'd0;
            len_reg    <= 5'd0;
            pos_reg    <= 5'd0;
            sum_reg    <= 12'd0;
            cks_lo_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            cks_lo_reg <= cks_lo_next;
        end
    end

endmodule

// ----- design/stfp_out_reg.sv -----
module stfp_out_reg
    import stfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t res_q
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    // A word loads only when the register is empty or being emptied this cycle.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign res_q     = data_reg;

endmodule

// ----- design/sync_type_frame_parser_top.sv -----
// Byte-stream frame parser: takes one received byte per word, hunts for a 0xff
// sync byte, then reads prefix, type, body and a little-endian 16-bit checksum,
// and gives one result word at the end of each frame (or at once for an unknown
// type). A byte is taken every cycle unless the output stalls: the parser state
// and its 12-bit adder are updated with each byte, and the result goes into a
// single output register. While that register holds a word that is not taken,
// input stalls; with out_ready held high the rate is one byte per cycle and a
// result appears in the cycle after the byte that completes the frame.
module sync_type_frame_parser_top
    import stfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_type,
    output logic [1:0]  frame_status,
    output logic [7:0]  prefix_byte,
    output logic [4:0]  frame_length,
    output logic [11:0] sum_computed,
    output logic [15:0] sum_received
);

    logic    step;
    logic    res_valid;
    result_t res;
    result_t res_q;

    assign in_ready = !out_valid || out_ready;
    assign step     = in_valid && in_ready;

    stfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    stfp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_q     (res_q)
    );

    assign frame_type   = res_q.frame_type;
    assign frame_status = res_q.frame_status;
    assign prefix_byte  = res_q.prefix_byte;
    assign frame_length = res_q.frame_length;
    assign sum_computed = res_q.sum_computed;
    assign sum_received = res_q.sum_received;

endmodule

// ----- design/stfp_checker.sv -----
module stfp_checker
    import stfp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  frame_type,
    input logic [1:0]  frame_status,
    input logic [7:0]  prefix_byte,
    input logic [4:0]  frame_length,
    input logic [11:0] sum_computed,
    input logic [15:0] sum_received
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_type)
            && $stable(frame_status) && $stable(prefix_byte)
            && $stable(frame_length) && $stable(sum_computed)
            && $stable(sum_received))
        else $error("result word changed while stalled");

    // With the output register full and not drained, no byte may be taken.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output register full");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status == ST_UNKNOWN |->
            frame_length == 5'd0 && sum_computed == 12'd0 && sum_received == 16'd0)
        else $error("unknown-type result with nonzero fields");

    a_known_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_status != ST_UNKNOWN |->
            frame_length == length_of_type(frame_type) && frame_length != 5'd0
            && ((frame_status == ST_OK) == ({4'd0, sum_computed} == sum_received)))
        else $error("frame result inconsistent with type or checksum");

endmodule

bind sync_type_frame_parser_top stfp_checker u_stfp_checker (.*);

// ----- tb/sync_type_frame_parser_checker.sv -----
`timescale 1ns / 100ps

module sync_type_frame_parser_checker
    import stfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  frame_type,
    input  logic [1:0]  frame_status,
    input  logic [7:0]  prefix_byte,
    input  logic [4:0]  frame_length,
    input  logic [11:0] sum_computed,
    input  logic [15:0] sum_received,
    output int          mismatches,
    output int          frames_outstanding
);

    localparam logic [7:0] FT_41 = 8'h41;
    localparam logic [7:0] FT_42 = 8'h42;
    localparam logic [7:0] FT_44 = 8'h44;
    localparam logic [7:0] FT_46 = 8'h46;
    localparam logic [7:0] FT_47 = 8'h47;
    localparam logic [7:0] FT_48 = 8'h48;
    localparam logic [7:0] FT_60 = 8'h60;

    logic [1:0]  phase;
    logic [7:0]  held_pfx;
    logic [7:0]  held_ft;
    logic [4:0]  want_len;
    logic [4:0]  pos;
    logic [11:0] acc;
    logic [7:0]  ck_lo;

    result_t frames_due[$];

    function automatic logic [4:0] frame_size(input logic [7:0] t);
        logic [4:0] n;
        case (t)
            FT_41:   n = 5'd17;
            FT_42:   n = 5'd12;
            FT_44:   n = 5'd7;
            FT_46:   n = 5'd8;
            FT_47:   n = 5'd6;
            FT_48:   n = 5'd11;
            FT_60:   n = 5'd12;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Advances the parser by one received byte and queues the frame it ends, if any.
    task automatic track_byte(input logic [7:0] b);
        result_t r;
        logic [4:0] n;
        logic [15:0] rcv;
        case (phase)
            PH_HUNT:
            begin
                if (b == SYNC_BYTE)
                    phase = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (b != SYNC_BYTE)
                begin
                    held_pfx = b;
                    phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                n = frame_size(b);
                held_ft = b;
                if (n == 5'd0)
                begin
                    want_len = 5'd0;
                    phase = PH_HUNT;
                    r.frame_type = b;
                    r.frame_status = ST_UNKNOWN;
                    r.prefix_byte = held_pfx;
                    r.frame_length = 5'd0;
                    r.sum_computed = 12'd0;
                    r.sum_received = 16'd0;
                    frames_due.push_back(r);
                end
                else
                begin
                    want_len = n;
                    pos = 5'd2;
                    acc = 12'(held_pfx) + 12'(b);
                    ck_lo = 8'd0;
                    phase = PH_BODY;
                end
            end
            default:
            begin
                if (want_len < MIN_LENGTH)
                    phase = PH_HUNT;
                else if (pos < want_len - 5'd2)
                begin
                    acc = acc + 12'(b);
                    pos = pos + 5'd1;
                end
                else if (pos == want_len - 5'd2)
                begin
                    ck_lo = b;
                    pos = pos + 5'd1;
                end
                else
                begin
                    rcv = {b, ck_lo};
                    r.frame_type = held_ft;
                    r.frame_status = ({4'd0, acc} == rcv) ? ST_OK : ST_MISMATCH;
                    r.prefix_byte = held_pfx;
                    r.frame_length = want_len;
                    r.sum_computed = acc;
                    r.sum_received = rcv;
                    frames_due.push_back(r);
                    phase = PH_HUNT;
                    pos = 5'd0;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            phase = PH_HUNT;
            held_pfx = 8'd0;
            held_ft = 8'd0;
            want_len = 5'd0;
            pos = 5'd0;
            acc = 12'd0;
            ck_lo = 8'd0;
            frames_due.delete();
            mismatches = 0;
            frames_outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("result word with no frame pending: frame_type 0x%0h", frame_type);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("frame_type", want.frame_type, frame_type);
                    check_field("frame_status", want.frame_status, frame_status);
                    check_field("prefix_byte", want.prefix_byte, prefix_byte);
                    check_field("frame_length", want.frame_length, frame_length);
                    check_field("sum_computed", want.sum_computed, sum_computed);
                    check_field("sum_received", want.sum_received, sum_received);
                end
            end
            frames_outstanding <= frames_due.size();
        end
    end

endmodule

// ----- tb/sync_type_frame_parser_top_tb.sv -----
`timescale 1ns / 100ps

module sync_type_frame_parser_top_tb;
    import stfp_pkg::*;

    localparam int CK_GOOD = 0;
    localparam int CK_FLIP = 1;
    localparam int CK_ANY  = 2;
    localparam int CK_ONES = 3;

    localparam int PHASE_BYTES = 263;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  frame_type;
    logic [1:0]  frame_status;
    logic [7:0]  prefix_byte;
    logic [4:0]  frame_length;
    logic [11:0] sum_computed;
    logic [15:0] sum_received;

    int mismatches;
    int frames_outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;

    logic [7:0] stream_q[$];
    logic [7:0] known_types[$];

    sync_type_frame_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_type   (frame_type),
        .frame_status (frame_status),
        .prefix_byte  (prefix_byte),
        .frame_length (frame_length),
        .sum_computed (sum_computed),
        .sum_received (sum_received)
    );

    sync_type_frame_parser_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .frame_type         (frame_type),
        .frame_status       (frame_status),
        .prefix_byte        (prefix_byte),
        .frame_length       (frame_length),
        .sum_computed       (sum_computed),
        .sum_received       (sum_received),
        .mismatches         (mismatches),
        .frames_outstanding (frames_outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
            send_byte(stream_q.pop_front());
    endtask

    // Queues sync bytes, prefix and type and, for a known type, the body and checksum.
    task automatic queue_frame(input logic [7:0] pfx, input logic [7:0] ftype,
                               input int syncs, input bit random_body, input int ck_mode);
        logic [4:0]  n;
        logic [11:0] sum;
        logic [15:0] ck;
        logic [7:0]  b;
        repeat (syncs)
            stream_q.push_back(SYNC_BYTE);
        stream_q.push_back(pfx);
        stream_q.push_back(ftype);
        sum = 12'(pfx) + 12'(ftype);
        n = length_of_type(ftype);
        if (n != 5'd0)
        begin
            repeat (int'(n) - 4)
            begin
                b = random_body ? 8'($urandom) : 8'hff;
                sum = sum + 12'(b);
                stream_q.push_back(b);
            end
            case (ck_mode)
                CK_GOOD: ck = {4'd0, sum};
                CK_FLIP: ck = {4'd0, sum} ^ (16'd1 << $urandom_range(15));
                CK_ONES: ck = 16'hffff;
                default: ck = 16'($urandom);
            endcase
            stream_q.push_back(ck[7:0]);
            stream_q.push_back(ck[15:8]);
        end
    endtask

    // Mostly whole frames with random content, with some line noise and cut-short frames.
    task automatic random_traffic(input int count);
        int stop;
        int r;
        int mode;
        logic [7:0] pfx;
        logic [7:0] ftype;
        stop = bytes_sent + count;
        while (bytes_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 6))
                    stream_q.push_back(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(0, 2))
                    stream_q.push_back(8'($urandom_range(0, 254)));
                pfx = 8'($urandom_range(0, 254));
                if ($urandom_range(99) < 85)
                    ftype = known_types[$urandom_range(known_types.size() - 1)];
                else
                    ftype = 8'($urandom);
                r = $urandom_range(99);
                mode = (r < 60) ? CK_GOOD : (r < 80) ? CK_FLIP : CK_ANY;
                queue_frame(pfx, ftype, $urandom_range(1, 3), 1'b1, mode);
                if (length_of_type(ftype) != 5'd0 && $urandom_range(99) < 6)
                begin
                    repeat ($urandom_range(1, 4))
                        void'(stream_q.pop_back());
                end
            end
            send_stream();
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("sync_type_frame_parser_top verification failed");
        $finish;
    end

    initial
    begin
        logic [7:0] shortest;
        logic [7:0] runner_up;
        for (int t = 0; t < 256; t++)
        begin
            if (length_of_type(8'(t)) != 5'd0)
                known_types.push_back(8'(t));
        end
        shortest = known_types[0];
        foreach (known_types[i])
        begin
            if (length_of_type(known_types[i]) < length_of_type(shortest))
                shortest = known_types[i];
        end
        runner_up = SYNC_BYTE;
        foreach (known_types[i])
        begin
            if (length_of_type(known_types[i]) > length_of_type(shortest)
                && (length_of_type(runner_up) == 5'd0
                    || length_of_type(known_types[i]) < length_of_type(runner_up)))
                runner_up = known_types[i];
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Noise before sync, a 0xff type, the shortest frame with all-ones body,
        // a bad checksum of all ones, and an ordinary unknown type.
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hfe);
        queue_frame(8'hfe, SYNC_BYTE, 2, 1'b0, CK_GOOD);
        queue_frame(8'h00, shortest, 1, 1'b0, CK_GOOD);
        queue_frame(8'h01, runner_up, 1, 1'b0, CK_ONES);
        queue_frame(8'h80, 8'h00, 1, 1'b0, CK_GOOD);
        send_stream();
        random_traffic(PHASE_BYTES);

        send_idle_pct = 63;
        recv_stall_pct = 0;
        random_traffic(PHASE_BYTES);

        send_idle_pct = 0;
        recv_stall_pct = 63;
        random_traffic(PHASE_BYTES / 2);
        // Hold the sender off until every pending result word has been taken.
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_outstanding != 0)
            @(posedge clk);
        random_traffic(PHASE_BYTES - PHASE_BYTES / 2);

        send_idle_pct = 28;
        recv_stall_pct = 28;
        random_traffic(PHASE_BYTES);

        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && frames_outstanding == 0)
            $display("sync_type_frame_parser_top verification clean");
        else
            $display("sync_type_frame_parser_top verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/stfp_pkg.sv
design/stfp_parser.sv
design/stfp_out_reg.sv
design/sync_type_frame_parser_top.sv
design/stfp_checker.sv
tb/sync_type_frame_parser_checker.sv
tb/sync_type_frame_parser_top_tb.sv
